>>> rtl/repeated_record_grouper_unit_defines.svh
//------------------------------------------------------------------------------
// repeated_record_grouper_unit_defines.svh
// Assertion macros shared by the checker files of the record grouper.
//------------------------------------------------------------------------------
`ifndef REPEATED_RECORD_GROUPER_UNIT_DEFINES_SVH
`define REPEATED_RECORD_GROUPER_UNIT_DEFINES_SVH

// cond must never hold while out of reset
`define RRG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

// ante at one edge implies cons at the next edge
`define RRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rrg_pkg.sv
//------------------------------------------------------------------------------
// rrg_pkg
// Types and constants of the repeated record grouper.
//------------------------------------------------------------------------------
`default_nettype none

package rrg_pkg;

	localparam int ROW_LEN  = 10;
	localparam int VAL_W    = 32;
	localparam int ROW_BITS = ROW_LEN * VAL_W;
	localparam int CNT_W    = 8;
	localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;
	localparam logic [CNT_W-1:0] MIN_REPEATS_RST = 8'd3;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef val_t [ROW_LEN-1:0] row_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // store the accepted word
		logic lead_rd;    // read leader row and its claim mark
		logic lead_take;  // latch leader, restart sweep after it
		logic probe;      // read the next candidate row
		logic next_lead;  // advance leader index
		logic pend_load;  // move current group into the pending result
		logic pend_zero;  // pending result becomes the empty result
		logic clear;      // end of set
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic lead_more;    // a leader with a later row exists
		logic lead_claimed; // leader row already belongs to a group
		logic sweep_last;   // probe index is the final stored row
		logic qualify;      // group count meets threshold, slot left
		logic pend_valid;   // a pending result is held
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/rrg_row_if.sv
//------------------------------------------------------------------------------
// rrg_row_if
// Input channel: one record of ten values and the last flag per word.
//------------------------------------------------------------------------------
`default_nettype none

interface rrg_row_if
	import rrg_pkg::*;
();
	logic valid;
	logic ready;
	logic signed [VAL_W-1:0] row_value_0;
	logic signed [VAL_W-1:0] row_value_1;
	logic signed [VAL_W-1:0] row_value_2;
	logic signed [VAL_W-1:0] row_value_3;
	logic signed [VAL_W-1:0] row_value_4;
	logic signed [VAL_W-1:0] row_value_5;
	logic signed [VAL_W-1:0] row_value_6;
	logic signed [VAL_W-1:0] row_value_7;
	logic signed [VAL_W-1:0] row_value_8;
	logic signed [VAL_W-1:0] row_value_9;
	logic last_row;

	modport source (
		output valid, row_value_0, row_value_1, row_value_2, row_value_3, row_value_4,
		output row_value_5, row_value_6, row_value_7, row_value_8, row_value_9, last_row,
		input  ready
	);
	modport sink (
		input  valid, row_value_0, row_value_1, row_value_2, row_value_3, row_value_4,
		input  row_value_5, row_value_6, row_value_7, row_value_8, row_value_9, last_row,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/rrg_group_if.sv
//------------------------------------------------------------------------------
// rrg_group_if
// Output channel: repeat count, repeated record and last flag per word.
//------------------------------------------------------------------------------
`default_nettype none

interface rrg_group_if
	import rrg_pkg::*;
();
	logic valid;
	logic ready;
	logic [CNT_W-1:0] repeat_count;
	logic signed [VAL_W-1:0] group_value_0;
	logic signed [VAL_W-1:0] group_value_1;
	logic signed [VAL_W-1:0] group_value_2;
	logic signed [VAL_W-1:0] group_value_3;
	logic signed [VAL_W-1:0] group_value_4;
	logic signed [VAL_W-1:0] group_value_5;
	logic signed [VAL_W-1:0] group_value_6;
	logic signed [VAL_W-1:0] group_value_7;
	logic signed [VAL_W-1:0] group_value_8;
	logic signed [VAL_W-1:0] group_value_9;
	logic last_group;

	modport source (
		output valid, repeat_count, group_value_0, group_value_1, group_value_2,
		output group_value_3, group_value_4, group_value_5, group_value_6,
		output group_value_7, group_value_8, group_value_9, last_group,
		input  ready
	);
	modport sink (
		input  valid, repeat_count, group_value_0, group_value_1, group_value_2,
		input  group_value_3, group_value_4, group_value_5, group_value_6,
		input  group_value_7, group_value_8, group_value_9, last_group,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/rrg_ram.sv
//------------------------------------------------------------------------------
// rrg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
//------------------------------------------------------------------------------
`default_nettype none

module rrg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

>>> rtl/rrg_datapath.sv
//------------------------------------------------------------------------------
// rrg_datapath
// Record and claim stores, leader/probe indexes, match counter and the
// pending result register that feeds the output channel.
//------------------------------------------------------------------------------
`default_nettype none

module rrg_datapath
	import rrg_pkg::*;
#(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_GROUPS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	output dp_stat_t              stat,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	input  wire row_t             in_row,
	output logic      [CNT_W-1:0] grp_count,
	output row_t                  grp_row
);
	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int GW = $clog2(MAX_GROUPS + 1);

	logic [CNT_W-1:0] min_repeats_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    lead_q;
	logic [AW-1:0]    probe_q;
	logic [AW-1:0]    probe_s1;
	logic             probe_vld_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [GW-1:0]    groups_q;
	logic             pend_vld_q;
	logic [CNT_W-1:0] pend_cnt_q;
	row_t             pend_row_q;
	row_t             leader_q;

	logic                full;
	logic                store_we;
	logic                row_match;
	logic [AW-1:0]       rd_addr;
	logic                mark_we;
	logic [AW-1:0]       mark_waddr;
	logic                mark_wdata;
	logic                mark_rdata;
	logic [ROW_BITS-1:0] row_rdata;

	assign full     = (count_q == CW'(MAX_ROWS));
	assign store_we = cmd.load & ~full;
	assign rd_addr  = cmd.lead_rd ? lead_q : probe_q;
	assign row_match = (row_rdata == leader_q);

	// loading clears the claim mark of the new row, so no clearing pass
	assign mark_we    = store_we | (probe_vld_s1 & row_match);
	assign mark_waddr = cmd.load ? count_q[AW-1:0] : probe_s1;
	assign mark_wdata = ~cmd.load;

	rrg_ram #(.WIDTH(ROW_BITS), .DEPTH(MAX_ROWS)) u_rows (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_row),
		.raddr (rd_addr),
		.rdata (row_rdata)
	);

	rrg_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_marks (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (rd_addr),
		.rdata (mark_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_repeats_q <= MIN_REPEATS_RST;
			count_q       <= '0;
			lead_q        <= '0;
			probe_q       <= '0;
			probe_vld_s1  <= 1'b0;
			cnt_q         <= '0;
			groups_q      <= '0;
			pend_vld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_repeats_q <= cfg_wdata;
			end
			if (store_we) begin
				count_q <= count_q + CW'(1);
			end
			probe_vld_s1 <= cmd.probe;
			if (cmd.lead_take) begin
				probe_q <= lead_q + AW'(1);
				cnt_q   <= '0;
			end else if (cmd.probe) begin
				probe_q <= probe_q + AW'(1);
			end
			// saturating match count
			if (probe_vld_s1 && row_match && cnt_q != COUNT_MAX) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.next_lead) begin
				lead_q <= lead_q + AW'(1);
			end
			if (cmd.pend_load) begin
				pend_vld_q <= 1'b1;
				groups_q   <= groups_q + GW'(1);
			end
			if (cmd.clear) begin
				count_q    <= '0;
				lead_q     <= '0;
				groups_q   <= '0;
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		probe_s1 <= probe_q;
		if (cmd.lead_take) begin
			leader_q <= row_rdata;
		end
		if (cmd.pend_load) begin
			pend_cnt_q <= cnt_q;
			pend_row_q <= leader_q;
		end else if (cmd.pend_zero) begin
			pend_cnt_q <= '0;
			pend_row_q <= '0;
		end
	end

	always_comb begin
		stat.lead_more    = (CW'(lead_q) + CW'(1)) < count_q;
		stat.lead_claimed = mark_rdata;
		stat.sweep_last   = (CW'(probe_q) == count_q - CW'(1));
		stat.qualify      = (cnt_q >= min_repeats_q) && (groups_q < GW'(MAX_GROUPS));
		stat.pend_valid   = pend_vld_q;
	end

	assign grp_count = pend_cnt_q;
	assign grp_row   = pend_row_q;
endmodule

`default_nettype wire

>>> rtl/rrg_ctrl.sv
//------------------------------------------------------------------------------
// rrg_ctrl
// Sequencer: loads records, walks leaders and probes, and hands out
// results one word behind so the final word can carry the last flag.
//------------------------------------------------------------------------------
`default_nettype none

module rrg_ctrl
	import rrg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_last,
	output logic          in_ready,
	output logic          out_valid,
	output logic          out_last,
	input  wire logic     out_ready,
	output dp_cmd_t       cmd,
	input  wire dp_stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_LEAD,
		S_SWEEP,
		S_DRAIN,
		S_DECIDE,
		S_EMIT,
		S_FINISH,
		S_EMIT_LAST
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_last) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= stat.lead_more ? S_LEAD : S_FINISH;
				end
				S_LEAD: begin
					state_q <= stat.lead_claimed ? S_SCAN : S_SWEEP;
				end
				S_SWEEP: begin
					if (stat.sweep_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last probe compares this cycle
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (stat.qualify && stat.pend_valid) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b0;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_EMIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_FINISH: begin
					out_valid_q <= 1'b1;
					out_last_q  <= 1'b1;
					state_q     <= S_EMIT_LAST;
				end
				S_EMIT_LAST: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						out_last_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					out_valid_q <= 1'b0;
					out_last_q  <= 1'b0;
					state_q     <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_SCAN: begin
				cmd.lead_rd = stat.lead_more;
			end
			S_LEAD: begin
				cmd.next_lead = stat.lead_claimed;
				cmd.lead_take = ~stat.lead_claimed;
			end
			S_SWEEP: begin
				cmd.probe = 1'b1;
			end
			S_DECIDE: begin
				cmd.pend_load = stat.qualify & ~stat.pend_valid;
				cmd.next_lead = ~(stat.qualify & stat.pend_valid);
			end
			S_EMIT: begin
				cmd.pend_load = out_ready;
				cmd.next_lead = out_ready;
			end
			S_FINISH: begin
				cmd.pend_zero = ~stat.pend_valid;
			end
			S_EMIT_LAST: begin
				cmd.clear = out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
endmodule

`default_nettype wire

>>> rtl/repeated_record_grouper_unit.sv
//------------------------------------------------------------------------------
// repeated_record_grouper_unit
// Stores a set of ten-value records, then reports up to MAX_GROUPS records that
// copy no earlier one and have min_repeats or more later exact copies, with counts.
//
//   channel  dir  handshake      payload
//   row      in   valid/ready    row_value_0..9, last_row
//   grp      out  valid/ready    repeat_count, group_value_0..9, last_group
//   cfg      in   cfg_we         cfg_wdata -> min_repeats
//
// Loading takes one cycle per record (one record RAM write port).
// After the final record, each unclaimed leader passes scan, lead, sweep (one probe
// per cycle over the later rows), drain and decide; a claimed one only scan and lead.
// The search pauses while a mid-search word waits for grp.ready; the final word
// goes out once the search ends. row.ready only in load.
// Reset is asynchronous; no clearing pass is needed after it.
//------------------------------------------------------------------------------
`default_nettype none

module repeated_record_grouper_unit
	import rrg_pkg::*;
#(
	parameter int MAX_ROWS   = 256,
	parameter int MAX_GROUPS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	rrg_row_if.sink               row,
	rrg_group_if.source           grp,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);
	dp_cmd_t          cmd;
	dp_stat_t         stat;
	row_t             in_row;
	row_t             out_row;
	logic [CNT_W-1:0] out_count;
	logic             in_ready;
	logic             out_valid;
	logic             out_last;

	assign in_row = {row.row_value_9, row.row_value_8, row.row_value_7, row.row_value_6,
		row.row_value_5, row.row_value_4, row.row_value_3, row.row_value_2,
		row.row_value_1, row.row_value_0};

	rrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (row.valid),
		.in_last   (row.last_row),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_last  (out_last),
		.out_ready (grp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	rrg_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_GROUPS(MAX_GROUPS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_row    (in_row),
		.grp_count (out_count),
		.grp_row   (out_row)
	);

	assign row.ready         = in_ready;
	assign grp.valid         = out_valid;
	assign grp.last_group    = out_last;
	assign grp.repeat_count  = out_count;
	assign grp.group_value_0 = out_row[0];
	assign grp.group_value_1 = out_row[1];
	assign grp.group_value_2 = out_row[2];
	assign grp.group_value_3 = out_row[3];
	assign grp.group_value_4 = out_row[4];
	assign grp.group_value_5 = out_row[5];
	assign grp.group_value_6 = out_row[6];
	assign grp.group_value_7 = out_row[7];
	assign grp.group_value_8 = out_row[8];
	assign grp.group_value_9 = out_row[9];
endmodule

`default_nettype wire

>>> rtl/rrg_checker.sv
//------------------------------------------------------------------------------
// rrg_checker
// Port-level checks of the record grouper, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

`include "repeated_record_grouper_unit_defines.svh"

module rrg_checker
	import rrg_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             in_last,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             out_last,
	input wire logic [CNT_W-1:0] out_count
);
	// loading and reporting never overlap
	`RRG_ASSERT_NEVER(a_no_overlap, clk, arst_n, in_ready && out_valid, "ready while a result is shown")

	// the final record starts the search and closes the input
	`RRG_ASSERT_NEXT(a_last_closes, clk, arst_n, in_valid && in_ready && in_last, !in_ready, "input still open after last record")

	// the final word of a set reopens the input
	`RRG_ASSERT_NEXT(a_set_done, clk, arst_n, out_valid && out_ready && out_last, in_ready && !out_valid, "not idle after final word")

	// a stalled result word holds
	`RRG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_count) && $stable(out_last), "stalled result changed")
endmodule

bind repeated_record_grouper_unit rrg_checker u_rrg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (row.valid),
	.in_ready  (row.ready),
	.in_last   (row.last_row),
	.out_valid (grp.valid),
	.out_ready (grp.ready),
	.out_last  (grp.last_group),
	.out_count (grp.repeat_count)
);

`default_nettype wire

>>> tb/repeated_record_grouper_unit_tb.sv
//------------------------------------------------------------------------------
// repeated_record_grouper_unit_tb
// Self-checking bench for the record grouper. Record sets are streamed
// into the row channel. A behavioral copy of the grouping rules predicts
// the result words for every accepted word, and the monitor compares them
// field by field in order. A directed table comes first, then random sets
// under several thresholds and idle patterns, and then a back-pressure phase.
//------------------------------------------------------------------------------

module repeated_record_grouper_unit_tb;
	import rrg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ROWS      = 256;
	localparam int MAX_GROUPS    = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;

	localparam row_t P_ZERO  = '0;
	localparam row_t P_ONES  = '1;
	localparam row_t P_MAX   = {ROW_LEN{32'h7FFF_FFFF}};
	localparam row_t P_MIN   = {ROW_LEN{32'h8000_0000}};
	localparam row_t P_ALT_A = {(ROW_LEN/2){32'h5555_5555, 32'hAAAA_AAAA}};
	localparam row_t P_ALT_B = {(ROW_LEN/2){32'hAAAA_AAAA, 32'h5555_5555}};

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		row_t             rec;
		logic             last;
	} group_t;

	typedef enum logic {STEP_ROWS, STEP_CFG} step_kind_t;

	typedef struct {
		step_kind_t       kind;
		logic [CNT_W-1:0] level;    // threshold for STEP_CFG
		row_t             rec;
		int unsigned      copies;
		bit               vary;     // make each copy distinct
		bit               last;     // last_row on the final copy
		bit               typed;    // single result given below
		logic [CNT_W-1:0] exp_cnt;
		bit               exp_zero;
	} dir_step_t;

	// kind, level, rec, copies, vary, last, typed, exp_cnt, exp_zero
	dir_step_t plan [21] = '{
		'{STEP_ROWS, 8'd0,   P_ZERO,  1,   1'b0, 1'b1, 1'b1, 8'd0,   1'b1}, // nothing qualifies
		'{STEP_ROWS, 8'd0,   P_MAX,   4,   1'b0, 1'b1, 1'b1, 8'd3,   1'b0},
		'{STEP_ROWS, 8'd0,   P_MIN,   4,   1'b0, 1'b1, 1'b1, 8'd3,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ALT_A, 1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ALT_B, 1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ALT_A, 1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ALT_B, 1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ALT_A, 1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ALT_A, 1,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
		'{STEP_CFG,  8'd0,   P_ZERO,  0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		// zero threshold: count-0 leaders qualify, the final row never leads
		'{STEP_ROWS, 8'd0,   P_ALT_B, 1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_MAX,   1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ZERO,  1,   1'b0, 1'b1, 1'b0, 8'd0,   1'b0},
		// 65 leaders, only the first MAX_GROUPS come out
		'{STEP_ROWS, 8'd0,   P_ALT_A, 66,  1'b1, 1'b1, 1'b0, 8'd0,   1'b0},
		'{STEP_CFG,  8'd255, P_ZERO,  0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		// row past MAX_ROWS dropped, count tops out at 255
		'{STEP_ROWS, 8'd0,   P_ONES,  257, 1'b0, 1'b1, 1'b1, 8'd255, 1'b0},
		'{STEP_ROWS, 8'd0,   P_MIN,   2,   1'b0, 1'b1, 1'b1, 8'd0,   1'b1},
		'{STEP_CFG,  8'd1,   P_ZERO,  0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ALT_B, 2,   1'b0, 1'b1, 1'b1, 8'd1,   1'b0},
		'{STEP_ROWS, 8'd0,   P_ZERO,  1,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0},
		'{STEP_ROWS, 8'd0,   P_MAX,   1,   1'b0, 1'b1, 1'b1, 8'd0,   1'b1}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	rrg_row_if   row ();
	rrg_group_if grp ();

	repeated_record_grouper_unit #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_GROUPS (MAX_GROUPS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.row       (row),
		.grp       (grp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// grouping state mirrored from the block
	row_t             kept_rows [MAX_ROWS];
	bit               claimed [MAX_ROWS];
	int unsigned      kept_n;
	logic [CNT_W-1:0] threshold = MIN_REPEATS_RST;

	group_t      awaited_groups [$];
	int unsigned mismatches;
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;
	int unsigned ready_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void predict_groups(input row_t r, input bit lst, output group_t res [$]);
		int unsigned hits;
		group_t g;
		res = {};
		if (kept_n < MAX_ROWS) begin
			kept_rows[kept_n] = r;
			kept_n++;
		end
		if (!lst)
			return;
		for (int i = 0; i + 1 < kept_n; i++) begin
			if (claimed[i])
				continue;
			hits = 0;
			for (int j = i + 1; j < kept_n; j++) begin
				if (kept_rows[j] == kept_rows[i]) begin
					claimed[j] = 1'b1;
					hits++;
				end
			end
			if (hits >= threshold && res.size() < MAX_GROUPS) begin
				g.cnt  = (hits > COUNT_MAX) ? COUNT_MAX : CNT_W'(hits);
				g.rec  = kept_rows[i];
				g.last = 1'b0;
				res.push_back(g);
			end
		end
		if (res.size() == 0) begin
			g = '0;
			res.push_back(g);
		end
		res[$].last = 1'b1;
		for (int i = 0; i < MAX_ROWS; i++)
			claimed[i] = 1'b0;
		kept_n = 0;
	endfunction

	function automatic val_t rand_val();
		case ($urandom_range(15))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic row_t rand_row();
		row_t r;
		for (int k = 0; k < ROW_LEN; k++)
			r[k] = rand_val();
		return r;
	endfunction

	// Offer one word, wait for it to be taken, then book its results.
	task automatic send_row(input row_t r, input bit lst, input bit use_typed,
			input group_t typed_res);
		group_t res [$];
		forever begin
			@(negedge clk);
			if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
				row.valid <= 1'b0;
			end else begin
				row.row_value_0 <= r[0];
				row.row_value_1 <= r[1];
				row.row_value_2 <= r[2];
				row.row_value_3 <= r[3];
				row.row_value_4 <= r[4];
				row.row_value_5 <= r[5];
				row.row_value_6 <= r[6];
				row.row_value_7 <= r[7];
				row.row_value_8 <= r[8];
				row.row_value_9 <= r[9];
				row.last_row    <= lst;
				row.valid       <= 1'b1;
				break;
			end
		end
		@(posedge clk);
		while (row.ready !== 1'b1)
			@(posedge clk);
		predict_groups(r, lst, res);
		if (use_typed && lst)
			awaited_groups.push_back(typed_res);
		else
			foreach (res[i])
				awaited_groups.push_back(res[i]);
	endtask

	// Drop valid and wait until every awaited group is out.
	task automatic settle();
		@(negedge clk);
		row.valid <= 1'b0;
		while (awaited_groups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [CNT_W-1:0] v);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		threshold = v;
	endtask

	// Mostly copies of a few records, plus near misses and fresh noise.
	task automatic send_random_set(input int unsigned n);
		row_t pool [3];
		int unsigned npool;
		int unsigned pick;
		int unsigned k;
		int unsigned b;
		row_t r;
		npool = $urandom_range(1, 3);
		for (int p = 0; p < 3; p++)
			pool[p] = rand_row();
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			r = pool[$urandom_range(npool - 1)];
			if (pick >= 90) begin
				r = rand_row();
			end else if (pick >= 80) begin
				k = $urandom_range(ROW_LEN - 1);
				b = $urandom_range(VAL_W - 1);
				r[k][b] = ~r[k][b];
			end
			send_row(r, i == n - 1, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
			input logic [CNT_W-1:0] thr, input int unsigned budget);
		int unsigned sent;
		int unsigned n;
		set_threshold(thr);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		sent = 0;
		while (sent < budget) begin
			n = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 30);
			send_random_set(n);
			sent += n;
		end
	endtask

	initial begin : result_sink
		grp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold != 0) begin
				ready_hold--;
				grp.ready <= 1'b0;
			end else begin
				grp.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	initial begin : result_monitor
		group_t want;
		row_t seen;
		forever begin
			@(posedge clk);
			if (arst_n && grp.valid === 1'b1 && grp.ready === 1'b1) begin
				seen = {grp.group_value_9, grp.group_value_8, grp.group_value_7,
					grp.group_value_6, grp.group_value_5, grp.group_value_4,
					grp.group_value_3, grp.group_value_2, grp.group_value_1,
					grp.group_value_0};
				if (awaited_groups.size() == 0) begin
					$error("result word with nothing awaited: repeat_count %0d",
						grp.repeat_count);
					mismatches++;
				end else begin
					want = awaited_groups.pop_front();
					if (grp.repeat_count !== want.cnt) begin
						$error("repeat_count: expected %0d, got %0d", want.cnt,
							grp.repeat_count);
						mismatches++;
					end
					for (int k = 0; k < ROW_LEN; k++) begin
						if (seen[k] !== want.rec[k]) begin
							$error("group_value_%0d: expected %0d, got %0d", k,
								want.rec[k], seen[k]);
							mismatches++;
						end
					end
					if (grp.last_group !== want.last) begin
						$error("last_group: expected %0d, got %0d", want.last,
							grp.last_group);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		row_t r;
		group_t typed_res;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		row.valid       = 1'b0;
		row.row_value_0 = '0;
		row.row_value_1 = '0;
		row.row_value_2 = '0;
		row.row_value_3 = '0;
		row.row_value_4 = '0;
		row.row_value_5 = '0;
		row.row_value_6 = '0;
		row.row_value_7 = '0;
		row.row_value_8 = '0;
		row.row_value_9 = '0;
		row.last_row    = 1'b0;
		kept_n          = 0;
		mismatches      = 0;
		src_idle_pct    = 0;
		snk_stall_pct   = 0;
		ready_hold      = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[s]) begin
			if (plan[s].kind == STEP_CFG) begin
				set_threshold(plan[s].level);
			end else begin
				typed_res.cnt  = plan[s].exp_cnt;
				typed_res.rec  = plan[s].exp_zero ? P_ZERO : plan[s].rec;
				typed_res.last = 1'b1;
				for (int c = 0; c < plan[s].copies; c++) begin
					r = plan[s].rec;
					if (plan[s].vary)
						r[0] = r[0] ^ val_t'(c);
					send_row(r, plan[s].last && c == plan[s].copies - 1,
						plan[s].typed, typed_res);
				end
			end
		end

		run_phase(0, 0, 8'd2, 6);
		run_phase(65, 0, 8'd1, 6);
		run_phase(0, 65, 8'd0, 6);
		run_phase(22, 22, CNT_W'($urandom_range(1, 4)), 6);

		// long receiver hold while sets keep coming: input must back up
		set_threshold(8'd1);
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		@(posedge clk);
		ready_hold = 400;
		send_random_set(6);
		send_random_set(6);
		settle();
		send_random_set(4);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/rrg_pkg.sv
rtl/rrg_row_if.sv
rtl/rrg_group_if.sv
rtl/rrg_ram.sv
rtl/rrg_datapath.sv
rtl/rrg_ctrl.sv
rtl/repeated_record_grouper_unit.sv
rtl/rrg_checker.sv
tb/repeated_record_grouper_unit_tb.sv
